### rtl/htbd_pkg.sv
// ----------------------------------------------------------------------------
// htbd_pkg
// Types, sizes and codes shared by the Huffman tree bit decoder files.
// ----------------------------------------------------------------------------
`default_nettype none

package htbd_pkg;

  localparam int MAX_NODES   = 512;
  localparam int STACK_DEPTH = 256;

  localparam int NODE_AW = $clog2(MAX_NODES);
  localparam int NODE_CW = $clog2(MAX_NODES + 1);
  localparam int STK_AW  = $clog2(STACK_DEPTH);
  localparam int STK_CW  = $clog2(STACK_DEPTH + 1);

  localparam logic [7:0] LEAF_TAG = 8'h4C;

  localparam logic [1:0] STATUS_OK  = 2'd0;
  localparam logic [1:0] STATUS_MID = 2'd1;
  localparam logic [1:0] STATUS_BAD = 2'd2;

  typedef enum logic [1:0] {
    OP_TREE   = 2'd0,
    OP_BIT    = 2'd1,
    OP_FINISH = 2'd2,
    OP_BEGIN  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_BIT  = 2'd1,
    S_POP  = 2'd2,
    S_DONE = 2'd3
  } state_t;

  typedef struct packed {
    logic               is_leaf;
    logic [7:0]         sym;
    logic [NODE_AW-1:0] right;
  } node_t;

  localparam int NODE_W = $bits(node_t);

endpackage

`default_nettype wire

### rtl/htbd_ram.sv
// ----------------------------------------------------------------------------
// htbd_ram
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module htbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/huffman_tree_bit_decoder_unit.sv
// ----------------------------------------------------------------------------
// huffman_tree_bit_decoder_unit
// Loads a Huffman tree from its preorder serialisation and decodes code bits.
// ----------------------------------------------------------------------------
// Each accepted request moves the control state out of idle; its result is
// then loaded into the output register once the output side is free.
// No new request is taken until that result is loaded. Code bits wait on the
// registered read of the node table, leaf symbols on that of the pending stack.
// Reset is synchronous and clears the control state; the node table and the
// pending stack are not cleared and hold nothing until written.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_tree_bit_decoder_unit
  import htbd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] opcode,
  input  wire logic [7:0] data_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            symbol_valid,
  output logic [7:0]      symbol,
  output logic [1:0]      status,
  output logic            tree_ready
);

  state_t state;
  state_t state_next;

  logic [NODE_CW-1:0] node_count;
  logic [STK_CW-1:0]  stack_depth;
  logic               expect_symbol;
  logic               tree_complete;
  logic [NODE_AW-1:0] current_node;
  logic [NODE_AW-1:0] cur_right;
  logic [NODE_AW-1:0] nxt_node;
  logic               root_leaf;
  logic [7:0]         root_sym;
  logic [NODE_AW-1:0] root_right;
  logic               res_valid;
  logic [7:0]         res_sym;
  logic [1:0]         res_status;

  logic               accept;
  logic               out_free;
  logic               out_load;
  op_t                op;

  logic               nt_we;
  logic [NODE_AW-1:0] nt_waddr;
  node_t              nt_wdata;
  logic               nt_re;
  logic [NODE_AW-1:0] nt_raddr;
  logic [NODE_W-1:0]  nt_rdata;
  node_t              nt_rd;

  logic               st_we;
  logic [STK_AW-1:0]  st_waddr;
  logic [NODE_AW-1:0] st_wdata;
  logic               st_re;
  logic [STK_AW-1:0]  st_raddr;
  logic [NODE_AW-1:0] st_rdata;

  logic [NODE_AW-1:0] right_of_cur;
  logic [NODE_CW-1:0] cur_inc;
  logic [NODE_AW-1:0] left_of_cur;
  logic [NODE_AW-1:0] bit_next;
  logic [NODE_AW-1:0] pop_right;

  logic               o_valid;
  logic [7:0]         o_sym;
  logic [1:0]         o_status;

  assign op       = op_t'(opcode);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign nt_rd    = node_t'(nt_rdata);

  assign right_of_cur = (current_node == '0) ? root_right : cur_right;
  assign cur_inc      = NODE_CW'(current_node) + NODE_CW'(1);
  assign left_of_cur  = (cur_inc >= NODE_CW'(MAX_NODES)) ? '0 : cur_inc[NODE_AW-1:0];
  assign bit_next     = data_byte[0] ? right_of_cur : left_of_cur;
  assign pop_right    = (node_count >= NODE_CW'(MAX_NODES)) ? '0
                                                            : node_count[NODE_AW-1:0];

  htbd_ram #(
    .WIDTH (NODE_W),
    .DEPTH (MAX_NODES)
  ) u_node_table (
    .clk   (clk),
    .we    (nt_we),
    .waddr (nt_waddr),
    .wdata (nt_wdata),
    .re    (nt_re),
    .raddr (nt_raddr),
    .rdata (nt_rdata)
  );

  htbd_ram #(
    .WIDTH (NODE_AW),
    .DEPTH (STACK_DEPTH)
  ) u_pending_stack (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_TREE: begin
              if (!tree_complete && expect_symbol && stack_depth != '0) begin
                state_next = S_POP;
              end else begin
                state_next = S_DONE;
              end
            end
            OP_BIT: begin
              if (tree_complete && !root_leaf) begin
                state_next = S_BIT;
              end else begin
                state_next = S_DONE;
              end
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_BIT, S_POP, S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != S_IDLE);
    out_load = (state != S_IDLE) && out_free;
    nt_we    = 1'b0;
    nt_waddr = '0;
    nt_wdata = '0;
    nt_re    = 1'b0;
    nt_raddr = bit_next;
    st_we    = 1'b0;
    st_waddr = stack_depth[STK_AW-1:0];
    st_wdata = node_count[NODE_AW-1:0];
    st_re    = 1'b0;
    st_raddr = '0;
    o_valid  = res_valid;
    o_sym    = res_sym;
    o_status = res_status;
    case (state)
      S_IDLE: begin
        if (accept && op == OP_TREE && !tree_complete) begin
          if (expect_symbol) begin
            nt_we            = 1'b1;
            nt_waddr         = NODE_AW'(node_count - NODE_CW'(1));
            nt_wdata.is_leaf = 1'b1;
            nt_wdata.sym     = data_byte;
            st_re            = (stack_depth != '0);
            st_raddr         = STK_AW'(stack_depth - STK_CW'(1));
          end else if (node_count < NODE_CW'(MAX_NODES)) begin
            nt_waddr = node_count[NODE_AW-1:0];
            if (data_byte == LEAF_TAG) begin
              nt_we            = 1'b1;
              nt_wdata.is_leaf = 1'b1;
            end else if (stack_depth < STK_CW'(STACK_DEPTH)) begin
              nt_we = 1'b1;
              st_we = 1'b1;
            end
          end
        end
        if (accept && op == OP_BIT && tree_complete && !root_leaf) begin
          nt_re = 1'b1;
        end
      end
      S_BIT: begin
        o_valid  = nt_rd.is_leaf;
        o_sym    = nt_rd.is_leaf ? nt_rd.sym : 8'd0;
        o_status = STATUS_OK;
      end
      S_POP: begin
        nt_we          = 1'b1;
        nt_waddr       = st_rdata;
        nt_wdata.right = pop_right;
        o_valid        = 1'b0;
        o_sym          = 8'd0;
        o_status       = STATUS_OK;
      end
      default: begin
        o_valid = res_valid;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      node_count    <= '0;
      stack_depth   <= '0;
      expect_symbol <= 1'b0;
      tree_complete <= 1'b0;
      current_node  <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (accept) begin
        case (op)
          OP_TREE: begin
            if (!tree_complete) begin
              if (expect_symbol) begin
                expect_symbol <= 1'b0;
                if (stack_depth == '0) begin
                  tree_complete <= 1'b1;
                  current_node  <= '0;
                end else begin
                  stack_depth <= stack_depth - STK_CW'(1);
                end
              end else if (node_count < NODE_CW'(MAX_NODES)) begin
                if (data_byte == LEAF_TAG) begin
                  node_count    <= node_count + NODE_CW'(1);
                  expect_symbol <= 1'b1;
                end else if (stack_depth < STK_CW'(STACK_DEPTH)) begin
                  node_count  <= node_count + NODE_CW'(1);
                  stack_depth <= stack_depth + STK_CW'(1);
                end
              end
            end
          end
          OP_BIT: begin
            if (tree_complete && root_leaf) begin
              current_node <= '0;
            end
          end
          OP_FINISH: begin
            current_node <= '0;
          end
          OP_BEGIN: begin
            node_count    <= '0;
            stack_depth   <= '0;
            expect_symbol <= 1'b0;
            tree_complete <= 1'b0;
            current_node  <= '0;
          end
          default: begin
            current_node <= current_node;
          end
        endcase
      end

      if (state == S_BIT && out_free) begin
        if (nt_rd.is_leaf) begin
          current_node <= '0;
        end else begin
          current_node <= nxt_node;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (nt_we && nt_waddr == '0) begin
      root_leaf  <= nt_wdata.is_leaf;
      root_sym   <= nt_wdata.sym;
      root_right <= nt_wdata.right;
    end
    if (state == S_BIT && out_free) begin
      cur_right <= nt_rd.right;
    end
    if (accept) begin
      nxt_node   <= bit_next;
      res_valid  <= 1'b0;
      res_sym    <= 8'd0;
      res_status <= STATUS_OK;
      case (op)
        OP_TREE: begin
          if (tree_complete) begin
            res_status <= STATUS_BAD;
          end else if (!expect_symbol) begin
            if (node_count >= NODE_CW'(MAX_NODES)) begin
              res_status <= STATUS_BAD;
            end else if (data_byte != LEAF_TAG && stack_depth >= STK_CW'(STACK_DEPTH)) begin
              res_status <= STATUS_BAD;
            end
          end
        end
        OP_BIT: begin
          if (!tree_complete) begin
            res_status <= STATUS_BAD;
          end else if (root_leaf) begin
            res_valid <= 1'b1;
            res_sym   <= root_sym;
          end
        end
        OP_FINISH: begin
          if (!tree_complete) begin
            res_status <= STATUS_BAD;
          end else if (current_node != '0) begin
            res_status <= STATUS_MID;
          end
        end
        default: begin
          res_status <= STATUS_OK;
        end
      endcase
    end
    if (out_load) begin
      symbol_valid <= o_valid;
      symbol       <= o_sym;
      status       <= o_status;
      tree_ready   <= tree_complete;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    node_count <= NODE_CW'(MAX_NODES))
    else $error("node count beyond table size");

  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    stack_depth <= STK_CW'(STACK_DEPTH))
    else $error("stack depth beyond stack size");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("accepted request left no work in progress");

  a_leaf_pending: assert property (@(posedge clk) disable iff (rst)
    expect_symbol |-> (node_count != '0 && !tree_complete))
    else $error("symbol expected with no leaf or with a complete tree");

  a_symbol_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && symbol_valid) |-> (status == STATUS_OK && tree_ready))
    else $error("symbol emitted with an error status or no tree");

endmodule

`default_nettype wire
